@@ hdl/bqd_pkg.sv @@
// Shared definitions for the biquad section: register indexes, microcode word,
// datapath control bundle and the microcode program itself.
// No dependencies.
`timescale 1ns / 1ps

package bqd_pkg;

    // Default widths of the fixed-point format
    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int COEF_FRAC_BITS_DEF = 14;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] REG_B0    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_B1    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_B2    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_A1    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_A2    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_INIT1 = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_INIT2 = 3'd6;

    // Microcode steps
    localparam int STEP_BITS = 3;
    localparam logic [STEP_BITS-1:0] STEP_WAIT    = 3'd0;
    localparam logic [STEP_BITS-1:0] STEP_ACC_D1  = 3'd1;
    localparam logic [STEP_BITS-1:0] STEP_ROUND   = 3'd2;
    localparam logic [STEP_BITS-1:0] STEP_MUL_A1  = 3'd3;
    localparam logic [STEP_BITS-1:0] STEP_SUB_A1  = 3'd4;
    localparam logic [STEP_BITS-1:0] STEP_SAVE_D1 = 3'd5;
    localparam logic [STEP_BITS-1:0] STEP_ADD_B2  = 3'd6;
    localparam logic [STEP_BITS-1:0] STEP_SAVE_D2 = 3'd7;

    // Multiplier coefficient select
    localparam logic [2:0] COEF_B0 = 3'd0;
    localparam logic [2:0] COEF_B1 = 3'd1;
    localparam logic [2:0] COEF_B2 = 3'd2;
    localparam logic [2:0] COEF_A1 = 3'd3;
    localparam logic [2:0] COEF_A2 = 3'd4;

    // Accumulator addend select
    localparam logic [1:0] BASE_ZERO = 2'd0;
    localparam logic [1:0] BASE_D1   = 2'd1;
    localparam logic [1:0] BASE_D2   = 2'd2;
    localparam logic [1:0] BASE_ACC  = 2'd3;

    // One control word of the program
    typedef struct packed {
        logic                 accept_ok;  // step may take an input beat
        logic                 mul_en;
        logic [2:0]           mul_coef;
        logic                 mul_use_y;
        logic                 acc_en;
        logic [1:0]           acc_base;
        logic                 acc_neg;
        logic                 y_ld;       // round, saturate, emit result beat
        logic                 d1_ld;
        logic                 d2_ld;
        logic [STEP_BITS-1:0] seq_next;   // next step when no input is taken
    } ucode_t;

    // Gated strobes from sequencer to datapath
    typedef struct packed {
        logic       x_ld;
        logic       init_ld;
        logic       mul_go;
        logic [2:0] mul_coef;
        logic       mul_use_x_in;
        logic       mul_use_y;
        logic       acc_go;
        logic [1:0] acc_base;
        logic       acc_neg;
        logic       y_go;
        logic       d1_go;
        logic       d2_go;
    } dp_ctrl_t;

    // Program ROM; an accepting step jumps to STEP_ACC_D1 on a beat
    function automatic ucode_t ucode_rom(input logic [STEP_BITS-1:0] step);
        ucode_t w;
        w = '0;
        case (step)
            STEP_WAIT: begin
                // wait for a beat, start b0*x on it
                w.accept_ok = 1'b1;
                w.mul_en    = 1'b1;
                w.mul_coef  = COEF_B0;
                w.seq_next  = STEP_WAIT;
            end
            STEP_ACC_D1: begin
                w.acc_en    = 1'b1;
                w.acc_base  = BASE_D1;
                w.mul_en    = 1'b1;
                w.mul_coef  = COEF_B1;
                w.seq_next  = STEP_ROUND;
            end
            STEP_ROUND: begin
                w.y_ld      = 1'b1;
                w.acc_en    = 1'b1;
                w.acc_base  = BASE_D2;
                w.seq_next  = STEP_MUL_A1;
            end
            STEP_MUL_A1: begin
                w.mul_en    = 1'b1;
                w.mul_coef  = COEF_A1;
                w.mul_use_y = 1'b1;
                w.seq_next  = STEP_SUB_A1;
            end
            STEP_SUB_A1: begin
                w.acc_en    = 1'b1;
                w.acc_base  = BASE_ACC;
                w.acc_neg   = 1'b1;
                w.mul_en    = 1'b1;
                w.mul_coef  = COEF_A2;
                w.mul_use_y = 1'b1;
                w.seq_next  = STEP_SAVE_D1;
            end
            STEP_SAVE_D1: begin
                w.d1_ld     = 1'b1;
                w.acc_en    = 1'b1;
                w.acc_base  = BASE_ZERO;
                w.acc_neg   = 1'b1;
                w.mul_en    = 1'b1;
                w.mul_coef  = COEF_B2;
                w.seq_next  = STEP_ADD_B2;
            end
            STEP_ADD_B2: begin
                w.acc_en    = 1'b1;
                w.acc_base  = BASE_ACC;
                w.seq_next  = STEP_SAVE_D2;
            end
            STEP_SAVE_D2: begin
                // finish this sample and take the next beat in the same cycle
                w.d2_ld     = 1'b1;
                w.accept_ok = 1'b1;
                w.mul_en    = 1'b1;
                w.mul_coef  = COEF_B0;
                w.seq_next  = STEP_WAIT;
            end
            default: begin
                w.seq_next  = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

@@ hdl/biquad_filter_df2t_top.sv @@
// Top level of the biquad section: configuration registers, microcode sequencer
// and output register. Depends on bqd_pkg and bqd_datapath.
`timescale 1ns / 1ps

// Second-order IIR section, transposed direct form II, fixed point.
// Input channel (s_valid/s_ready): one signed sample per beat plus a restart
// flag that reloads both delay states from the init registers first.
// Output channel (m_valid/m_ready): one rounded, saturated sample per input
// beat, with a flag set when saturation clipped it.
// Configuration: cfg_wr_en/cfg_index/cfg_data write one register per cycle;
// indexes beyond the list are ignored. Write only while the block is idle.
// Schedule: a small microcode program of 8 steps runs five multiplies through
// one shared multiplier; the last step also takes the next beat, so back-to-back
// samples skip the wait step, and a new sample is taken only as the last finishes.
// Result path: product register, then accumulator, then output register.
// Reset: coefficients go to a pass-through filter (b0 = 1.0, others 0), init
// values and delay states to zero, sequencer to the wait step.
// Stall: a pending result beat holds the sequencer in its output step until
// taken; the next input beat is accepted only once an accepting step is reached.
module biquad_filter_df2t_top
    import bqd_pkg::*;
#(
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    // configuration
    input  logic                                          cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]                       cfg_index,
    input  logic [SAMPLE_BITS+COEF_FRAC_BITS+3:0]         cfg_data,
    // input channel
    input  logic                                          s_valid,
    output logic                                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0]                 s_sample_in,
    input  logic                                          s_restart,
    // result channel
    output logic                                          m_valid,
    input  logic                                          m_ready,
    output logic signed [SAMPLE_BITS-1:0]                 m_sample_out,
    output logic                                          m_clipped
);

    localparam int COEF_BITS  = COEF_FRAC_BITS + 2;
    localparam int STATE_BITS = SAMPLE_BITS + COEF_FRAC_BITS + 4;
    localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC_BITS;

    logic signed [COEF_BITS-1:0]   coef_b0_reg;
    logic signed [COEF_BITS-1:0]   coef_b1_reg;
    logic signed [COEF_BITS-1:0]   coef_b2_reg;
    logic signed [COEF_BITS-1:0]   coef_a1_reg;
    logic signed [COEF_BITS-1:0]   coef_a2_reg;
    logic signed [STATE_BITS-1:0]  init_one_reg;
    logic signed [STATE_BITS-1:0]  init_two_reg;

    logic [STEP_BITS-1:0]          step_reg;
    logic [STEP_BITS-1:0]          step_next;
    ucode_t                        uc;
    dp_ctrl_t                      dp_ctrl;
    logic                          accept;
    logic                          stall;
    logic                          go;

    logic                          m_valid_reg;
    logic signed [SAMPLE_BITS-1:0] m_sample_out_reg;
    logic                          m_clipped_reg;
    logic signed [SAMPLE_BITS-1:0] y_next;
    logic                          clip_next;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_b0_reg  <= COEF_ONE;
            coef_b1_reg  <= '0;
            coef_b2_reg  <= '0;
            coef_a1_reg  <= '0;
            coef_a2_reg  <= '0;
            init_one_reg <= '0;
            init_two_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_B0:    coef_b0_reg  <= cfg_data[COEF_BITS-1:0];
                REG_B1:    coef_b1_reg  <= cfg_data[COEF_BITS-1:0];
                REG_B2:    coef_b2_reg  <= cfg_data[COEF_BITS-1:0];
                REG_A1:    coef_a1_reg  <= cfg_data[COEF_BITS-1:0];
                REG_A2:    coef_a2_reg  <= cfg_data[COEF_BITS-1:0];
                REG_INIT1: init_one_reg <= cfg_data;
                REG_INIT2: init_two_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Fetch the control word and decide the next step
    always_comb begin
        uc      = ucode_rom(step_reg);
        s_ready = uc.accept_ok;
        accept  = s_valid && uc.accept_ok;
        stall   = uc.y_ld && m_valid_reg && !m_ready;
        go      = !stall;
        if (stall) begin
            step_next = step_reg;
        end else if (accept) begin
            step_next = STEP_ACC_D1;
        end else begin
            step_next = uc.seq_next;
        end
    end

    // Gate the control word into datapath strobes
    always_comb begin
        dp_ctrl.x_ld         = accept;
        dp_ctrl.init_ld      = accept && s_restart;
        dp_ctrl.mul_go       = uc.mul_en && go && (!uc.accept_ok || accept);
        dp_ctrl.mul_coef     = uc.mul_coef;
        dp_ctrl.mul_use_x_in = uc.accept_ok;
        dp_ctrl.mul_use_y    = uc.mul_use_y;
        dp_ctrl.acc_go       = uc.acc_en && go;
        dp_ctrl.acc_base     = uc.acc_base;
        dp_ctrl.acc_neg      = uc.acc_neg;
        dp_ctrl.y_go         = uc.y_ld && go;
        dp_ctrl.d1_go        = uc.d1_ld && go;
        dp_ctrl.d2_go        = uc.d2_ld && go;
    end

    // Step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_WAIT;
        end else begin
            step_reg <= step_next;
        end
    end

    bqd_datapath #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .dp_ctrl   (dp_ctrl),
        .x_in      (s_sample_in),
        .coef_b0   (coef_b0_reg),
        .coef_b1   (coef_b1_reg),
        .coef_b2   (coef_b2_reg),
        .coef_a1   (coef_a1_reg),
        .coef_a2   (coef_a2_reg),
        .init_one  (init_one_reg),
        .init_two  (init_two_reg),
        .y_next    (y_next),
        .clip_next (clip_next)
    );

    // Output register: load a result beat, drop valid when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (dp_ctrl.y_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_ctrl.y_go) begin
            m_sample_out_reg <= y_next;
            m_clipped_reg    <= clip_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_out_reg;
    assign m_clipped    = m_clipped_reg;

    // A stalled output step must not advance
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        stall |=> (step_reg == STEP_ROUND))
        else $error("sequencer left the output step while stalled");

    // An accepted beat always starts the program at its first compute step
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (step_reg == STEP_ACC_D1))
        else $error("accepted beat did not start the program");

    // Result beats and input beats never share a step
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_ctrl.y_go |-> !s_ready)
        else $error("result loaded in an accepting step");

    // Valid rises only from a result load
    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(dp_ctrl.y_go))
        else $error("result valid rose without a load");

    // A clipped result sits at one of the rails
    a_clip_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_clipped_reg) |->
            ((m_sample_out_reg == {1'b0, {(SAMPLE_BITS-1){1'b1}}}) ||
             (m_sample_out_reg == {1'b1, {(SAMPLE_BITS-1){1'b0}}})))
        else $error("clipped result not at a rail");

endmodule

@@ hdl/bqd_datapath.sv @@
// Biquad datapath: shared multiplier, accumulator, round/saturate and delay states.
// Depends on bqd_pkg; driven by the microcode sequencer in the top level.
`timescale 1ns / 1ps

module bqd_datapath
    import bqd_pkg::*;
#(
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  dp_ctrl_t                                      dp_ctrl,
    input  logic signed [SAMPLE_BITS-1:0]                 x_in,
    input  logic signed [COEF_FRAC_BITS+1:0]              coef_b0,
    input  logic signed [COEF_FRAC_BITS+1:0]              coef_b1,
    input  logic signed [COEF_FRAC_BITS+1:0]              coef_b2,
    input  logic signed [COEF_FRAC_BITS+1:0]              coef_a1,
    input  logic signed [COEF_FRAC_BITS+1:0]              coef_a2,
    input  logic signed [SAMPLE_BITS+COEF_FRAC_BITS+3:0]  init_one,
    input  logic signed [SAMPLE_BITS+COEF_FRAC_BITS+3:0]  init_two,
    output logic signed [SAMPLE_BITS-1:0]                 y_next,
    output logic                                          clip_next
);

    localparam int COEF_BITS  = COEF_FRAC_BITS + 2;
    localparam int STATE_BITS = SAMPLE_BITS + COEF_FRAC_BITS + 4;
    localparam int PROD_BITS  = COEF_BITS + SAMPLE_BITS;
    localparam int ACC_BITS   = STATE_BITS + 1;
    localparam int TOP_BITS   = ACC_BITS - SAMPLE_BITS + 1;

    localparam logic signed [ACC_BITS-1:0] ACC_HALF =
        ACC_BITS'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [SAMPLE_BITS-1:0] Y_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] Y_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [STATE_BITS-1:0]  S_MAX = {1'b0, {(STATE_BITS-1){1'b1}}};
    localparam logic signed [STATE_BITS-1:0]  S_MIN = {1'b1, {(STATE_BITS-1){1'b0}}};

    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SAMPLE_BITS-1:0] y_reg;
    logic signed [PROD_BITS-1:0]   prod_reg;
    logic signed [PROD_BITS-1:0]   prod_next;
    logic signed [ACC_BITS-1:0]    acc_reg;
    logic signed [ACC_BITS-1:0]    acc_next;
    logic signed [STATE_BITS-1:0]  d1_reg;
    logic signed [STATE_BITS-1:0]  d2_reg;

    logic signed [COEF_BITS-1:0]   coef_sel;
    logic signed [SAMPLE_BITS-1:0] opnd_sel;
    logic signed [ACC_BITS-1:0]    base_sel;
    logic signed [ACC_BITS-1:0]    prod_ext;
    logic signed [ACC_BITS-1:0]    rnd;
    logic signed [ACC_BITS-1:0]    shr;
    logic        [TOP_BITS-1:0]    shr_top;
    logic signed [STATE_BITS-1:0]  st_sat;

    // Select multiplier operands
    always_comb begin
        case (dp_ctrl.mul_coef)
            COEF_B0: coef_sel = coef_b0;
            COEF_B1: coef_sel = coef_b1;
            COEF_B2: coef_sel = coef_b2;
            COEF_A1: coef_sel = coef_a1;
            COEF_A2: coef_sel = coef_a2;
            default: coef_sel = '0;
        endcase
        if (dp_ctrl.mul_use_y) begin
            opnd_sel = y_reg;
        end else if (dp_ctrl.mul_use_x_in) begin
            opnd_sel = x_in;
        end else begin
            opnd_sel = x_reg;
        end
    end

    assign prod_next = coef_sel * opnd_sel;

    // Accumulate: addend plus or minus the registered product
    always_comb begin
        case (dp_ctrl.acc_base)
            BASE_ZERO: base_sel = '0;
            BASE_D1:   base_sel = ACC_BITS'(d1_reg);
            BASE_D2:   base_sel = ACC_BITS'(d2_reg);
            BASE_ACC:  base_sel = acc_reg;
            default:   base_sel = '0;
        endcase
        prod_ext = ACC_BITS'(prod_reg);
        acc_next = dp_ctrl.acc_neg ? (base_sel - prod_ext) : (base_sel + prod_ext);
    end

    // Round half up, then saturate to the sample range
    always_comb begin
        rnd       = acc_reg + ACC_HALF;
        shr       = rnd >>> COEF_FRAC_BITS;
        shr_top   = shr[ACC_BITS-1:SAMPLE_BITS-1];
        clip_next = !((&shr_top) | ~(|shr_top));
        if (!clip_next) begin
            y_next = shr[SAMPLE_BITS-1:0];
        end else if (shr[ACC_BITS-1]) begin
            y_next = Y_MIN;
        end else begin
            y_next = Y_MAX;
        end
    end

    // Clamp the accumulator to the state range
    always_comb begin
        if (acc_reg[ACC_BITS-1] == acc_reg[ACC_BITS-2]) begin
            st_sat = acc_reg[STATE_BITS-1:0];
        end else if (acc_reg[ACC_BITS-1]) begin
            st_sat = S_MIN;
        end else begin
            st_sat = S_MAX;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (dp_ctrl.x_ld) begin
            x_reg <= x_in;
        end
        if (dp_ctrl.mul_go) begin
            prod_reg <= prod_next;
        end
        if (dp_ctrl.acc_go) begin
            acc_reg <= acc_next;
        end
        if (dp_ctrl.y_go) begin
            y_reg <= y_next;
        end
    end

    // Delay states; a restart beat overrides the pending update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1_reg <= '0;
            d2_reg <= '0;
        end else begin
            if (dp_ctrl.init_ld) begin
                d1_reg <= init_one;
            end else if (dp_ctrl.d1_go) begin
                d1_reg <= st_sat;
            end
            if (dp_ctrl.init_ld) begin
                d2_reg <= init_two;
            end else if (dp_ctrl.d2_go) begin
                d2_reg <= st_sat;
            end
        end
    end

endmodule
